// ----- rtl/trum_pkg.sv -----
// ----------------------------------------------------------------------------
// trum_pkg
// Types and constants shared by the task runtime usage monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package trum_pkg;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned USAGE_W = 14;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [USAGE_W-1:0] usage_t;

  // request kinds
  localparam logic REQ_SNAPSHOT = 1'b0;
  localparam logic REQ_TASK     = 1'b1;

  // full scale, hundredths of a percent
  localparam usage_t USAGE_FULL = usage_t'(10000);

  // quotient bits produced by the serial divider
  localparam int unsigned QUO_STEPS = USAGE_W;

endpackage

`default_nettype wire

// ----- rtl/task_runtime_usage_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// task_runtime_usage_monitor_unit
// Per-task runtime share in hundredths of a percent, from runtime snapshots.
// ----------------------------------------------------------------------------
// A snapshot request is handled in the idle state and never raises busy. A
// task sample raises busy for the slot search, which runs up to the first
// matching handle (through all TASK_SLOTS entries when none matches), and
// for the steps below; a saturated sample skips the divider.
// The slot search reads the history memory one entry per cycle, then
// S_CHANGE forms the change, S_MULT multiplies it by 10000 and a restoring
// divider produces the quotient one bit per cycle. The result strobe
// comes in the cycle after the last step; busy is already low then, so the
// next request can be taken in that cycle. The receiver cannot stall.
`default_nettype none

module task_runtime_usage_monitor_unit #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  trum_pkg::cnt_t    counter_value_i,
  input  trum_pkg::cnt_t    task_handle_i,
  input  trum_pkg::slot_t   slot_i,
  output logic              result_valid_o,
  output trum_pkg::slot_t   out_slot_o,
  output trum_pkg::usage_t  usage_hundredths_o,
  output logic              saturated_o
);

  import trum_pkg::*;

  localparam int unsigned AW   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned XW   = 9;
  localparam int unsigned PW   = CNT_W + USAGE_W;
  localparam int unsigned STW  = $clog2(QUO_STEPS);
  localparam logic [AW-1:0]  LAST_IDX  = AW'(TASK_SLOTS - 1);
  localparam logic [STW-1:0] LAST_STEP = STW'(QUO_STEPS - 1);
  localparam logic [XW-1:0]  SLOTS_X   = XW'(TASK_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHANGE,
    S_MULT,
    S_DIV
  } state_e;

  state_e              state_q;
  cnt_t                handle_q, cnt_q, prev_q, change_q, rem_q;
  slot_t               slot_q;
  logic [AW-1:0]       idx_q;
  logic                pend_q, pend_last_q;
  logic [USAGE_W-1:0]  lo_q, quo_q;
  logic [STW-1:0]      step_q;
  cnt_t                prior_total_q, total_delta_q;
  logic                snap_ok_q;
  logic                result_valid_q, sat_q;
  usage_t              usage_q;
  slot_t               out_slot_q;
  logic [TASK_SLOTS-1:0] valid_q;

  logic [2*CNT_W-1:0]  mem_q [TASK_SLOTS];
  logic [2*CNT_W-1:0]  rd_q;
  logic                rd_vld_q;

  logic                accept;
  cnt_t                snap_delta;
  cnt_t                rd_handle, rd_runtime;
  logic                hit;
  logic [PW-1:0]       prod;
  logic [CNT_W:0]      trial, trial_sub;
  logic                ge;
  logic [XW-1:0]       slot_x;
  logic                in_range;
  logic                over;
  logic                finish;
  logic                wr_en;

  assign accept     = start && !busy;
  assign snap_delta = counter_value_i - prior_total_q;
  assign rd_handle  = rd_vld_q ? rd_q[2*CNT_W-1:CNT_W] : '0;
  assign rd_runtime = rd_vld_q ? rd_q[CNT_W-1:0] : '0;
  assign hit        = pend_q && (rd_handle == handle_q);
  assign prod       = PW'(change_q) * PW'(USAGE_FULL);
  assign trial      = {rem_q, lo_q[USAGE_W-1]};
  assign trial_sub  = trial - {1'b0, total_delta_q};
  assign ge         = trial >= {1'b0, total_delta_q};
  assign slot_x     = {{(XW-SLOT_W){1'b0}}, slot_q};
  assign in_range   = slot_x < SLOTS_X;
  assign over       = change_q > total_delta_q;
  assign finish     = ((state_q == S_DIV) && (step_q == LAST_STEP)) ||
                      ((state_q == S_MULT) && over);
  assign wr_en      = finish && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      handle_q       <= '0;
      cnt_q          <= '0;
      prev_q         <= '0;
      change_q       <= '0;
      rem_q          <= '0;
      slot_q         <= '0;
      idx_q          <= '0;
      pend_q         <= 1'b0;
      pend_last_q    <= 1'b0;
      lo_q           <= '0;
      quo_q          <= '0;
      step_q         <= '0;
      prior_total_q  <= '0;
      total_delta_q  <= '0;
      snap_ok_q      <= 1'b0;
      result_valid_q <= 1'b0;
      sat_q          <= 1'b0;
      usage_q        <= '0;
      out_slot_q     <= '0;
      valid_q        <= '0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_type_i == REQ_SNAPSHOT) begin
              if ((counter_value_i == '0) || (snap_delta == '0)) begin
                snap_ok_q <= 1'b0;
              end else begin
                snap_ok_q     <= 1'b1;
                total_delta_q <= snap_delta;
                prior_total_q <= counter_value_i;
              end
            end else if (snap_ok_q && (total_delta_q != '0)) begin
              handle_q    <= task_handle_i;
              cnt_q       <= counter_value_i;
              slot_q      <= slot_i;
              idx_q       <= '0;
              pend_q      <= 1'b0;
              pend_last_q <= 1'b0;
              state_q     <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            prev_q  <= rd_runtime;
            state_q <= S_CHANGE;
          end else if (pend_q && pend_last_q) begin
            prev_q  <= '0;
            state_q <= S_CHANGE;
          end else begin
            pend_q      <= 1'b1;
            pend_last_q <= (idx_q == LAST_IDX);
            if (idx_q != LAST_IDX) begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_CHANGE: begin
          change_q <= cnt_q - prev_q;
          state_q  <= S_MULT;
        end
        S_MULT: begin
          if (over) begin
            usage_q        <= USAGE_FULL;
            sat_q          <= 1'b1;
            out_slot_q     <= slot_q;
            result_valid_q <= 1'b1;
            state_q        <= S_IDLE;
          end else begin
            rem_q   <= prod[PW-1:USAGE_W];
            lo_q    <= prod[USAGE_W-1:0];
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
          lo_q   <= {lo_q[USAGE_W-2:0], 1'b0};
          quo_q  <= {quo_q[USAGE_W-2:0], ge};
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            usage_q        <= {quo_q[USAGE_W-2:0], ge};
            sat_q          <= 1'b0;
            out_slot_q     <= slot_q;
            result_valid_q <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (wr_en) begin
        valid_q[slot_x[AW-1:0]] <= 1'b1;
      end
    end
  end

  // history memory: handle in the upper half, runtime in the lower half
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[slot_x[AW-1:0]] <= {handle_q, cnt_q};
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[idx_q];
    end
  end

  assign busy               = (state_q != S_IDLE);
  assign result_valid_o     = result_valid_q;
  assign out_slot_o         = out_slot_q;
  assign usage_hundredths_o = usage_q;
  assign saturated_o        = sat_q;

  a_usage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (usage_hundredths_o <= USAGE_FULL))
    else $error("usage above full scale");

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |-> (usage_hundredths_o == USAGE_FULL))
    else $error("saturated result not at full scale");

  a_no_strobe_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobe right after an accepted request");

  a_delta_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_ok_q |-> (total_delta_q != '0))
    else $error("armed snapshot with zero delta");

  a_idle_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while result is shown");

endmodule

`default_nettype wire
